// ----- rtl/core/page_table_walker_top_macros.svh -----
// ----------------------------------------------------------------------------
// page_table_walker_top_macros
// assertion macros shared by the page table walker rtl; they use the clock
// and reset signals of the module that expands them
// ----------------------------------------------------------------------------
`ifndef PAGE_TABLE_WALKER_TOP_MACROS_SVH
`define PAGE_TABLE_WALKER_TOP_MACROS_SVH

// antecedent implies consequent in the same cycle
`define PTW_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("page table walker assertion failed");

// antecedent implies consequent in the next cycle
`define PTW_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("page table walker assertion failed");

`endif

// ----- rtl/core/ptw_pkg.sv -----
// ----------------------------------------------------------------------------
// ptw_pkg
// codes, constants and control types of the page table walker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptw_pkg;

   localparam int PAGE_SHIFT   = 12;
   localparam int LEVEL_STRIDE = 9;
   localparam int INDEX_BITS   = 9;
   localparam int FAULT_BITS   = 3;

   typedef enum logic {
      REQ_TRANSLATE = 1'b0,
      REQ_ENTRY     = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      RSP_READ  = 2'd0,
      RSP_DONE  = 2'd1,
      RSP_FAULT = 2'd2
   } rsp_kind_type;

   // per-transfer walk control from the step logic to the state and result registers
   typedef struct packed {
      logic emit;
      logic start;
      logic descend;
      logic finish;
   } ptw_ctrl_type;

endpackage

// ----- rtl/core/ptw_req_if.sv -----
// ----------------------------------------------------------------------------
// ptw_req_if
// request channel: translate requests and table entry read returns
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ptw_req_if #(
   parameter int VADDR_BITS = 48,
   parameter int PADDR_BITS = 52
);
   logic                  valid;
   logic                  ready;
   logic                  kind;
   logic [PADDR_BITS-1:0] root_table_addr;
   logic [VADDR_BITS-1:0] virt_addr;
   logic [63:0]           entry_data;

   modport source (
      output valid, kind, root_table_addr, virt_addr, entry_data,
      input  ready
   );

   modport sink (
      input  valid, kind, root_table_addr, virt_addr, entry_data,
      output ready
   );
endinterface

// ----- rtl/core/ptw_rsp_if.sv -----
// ----------------------------------------------------------------------------
// ptw_rsp_if
// result channel: entry reads, finished translations and faults
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ptw_rsp_if #(
   parameter int PADDR_BITS = 52
);
   logic                  valid;
   logic                  ready;
   logic [1:0]            result_kind;
   logic [PADDR_BITS-1:0] read_addr;
   logic [PADDR_BITS-1:0] phys_addr;
   logic [2:0]            fault_level;
   logic                  leaf_user;
   logic                  leaf_writable;
   logic                  leaf_executable;

   modport source (
      output valid, result_kind, read_addr, phys_addr, fault_level,
             leaf_user, leaf_writable, leaf_executable,
      input  ready
   );

   modport sink (
      input  valid, result_kind, read_addr, phys_addr, fault_level,
             leaf_user, leaf_writable, leaf_executable,
      output ready
   );
endinterface

// ----- rtl/core/ptw_step.sv -----
// ----------------------------------------------------------------------------
// ptw_step
// combinational walk step: decodes one transfer against the walk state and
// forms the result and the state control
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptw_step #(
   parameter int VADDR_BITS   = 48,
   parameter int PADDR_BITS   = 52,
   parameter int TABLE_LEVELS = 4,
   parameter int LEVEL_BITS   = 2
) (
   input  logic                   fire,
   input  logic                   kind,
   input  logic [PADDR_BITS-1:0]  root_table_addr,
   input  logic [VADDR_BITS-1:0]  virt_addr,
   input  logic [63:0]            entry_data,
   input  logic                   busy,
   input  logic [LEVEL_BITS-1:0]  level,
   input  logic [VADDR_BITS-1:0]  saved_vaddr,
   output ptw_pkg::ptw_ctrl_type  ctrl,
   output logic [1:0]             result_kind,
   output logic [PADDR_BITS-1:0]  read_addr,
   output logic [PADDR_BITS-1:0]  phys_addr,
   output logic [2:0]             fault_level,
   output logic                   leaf_user,
   output logic                   leaf_writable,
   output logic                   leaf_executable
);
   import ptw_pkg::*;

   localparam logic [LEVEL_BITS-1:0] TOP_LEVEL = LEVEL_BITS'(TABLE_LEVELS - 1);

   logic                  is_req;
   logic                  present;
   logic [VADDR_BITS-1:0] sel_va;
   logic [LEVEL_BITS-1:0] sel_level;
   logic [INDEX_BITS-1:0] index;
   logic [PADDR_BITS-1:0] entry_base;
   logic [PADDR_BITS-1:0] sel_base;

   assign is_req     = (kind == REQ_TRANSLATE);
   assign present    = entry_data[0];
   assign entry_base = {entry_data[PADDR_BITS-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};

   // table index of the entry to fetch next
   assign sel_va    = is_req ? virt_addr : saved_vaddr;
   assign sel_level = is_req ? TOP_LEVEL : level - 1'b1;
   assign index     = INDEX_BITS'(sel_va >> (PAGE_SHIFT + LEVEL_STRIDE * int'(sel_level)));
   assign sel_base  = is_req ? root_table_addr : entry_base;

   always_comb begin
      ctrl            = '0;
      result_kind     = RSP_READ;
      read_addr       = '0;
      phys_addr       = '0;
      fault_level     = '0;
      leaf_user       = 1'b0;
      leaf_writable   = 1'b0;
      leaf_executable = 1'b0;
      if (fire && is_req && !busy) begin
         ctrl.emit   = 1'b1;
         ctrl.start  = 1'b1;
         read_addr   = sel_base + PADDR_BITS'({index, 3'b000});
      end else if (fire && !is_req && busy) begin
         ctrl.emit = 1'b1;
         if (!present) begin
            ctrl.finish = 1'b1;
            result_kind = RSP_FAULT;
            fault_level = FAULT_BITS'(level) + 3'd1;
         end else if (level == '0) begin
            ctrl.finish     = 1'b1;
            result_kind     = RSP_DONE;
            phys_addr       = entry_base | PADDR_BITS'(saved_vaddr[PAGE_SHIFT-1:0]);
            leaf_user       = entry_data[2];
            leaf_writable   = entry_data[1];
            leaf_executable = ~entry_data[63];
         end else begin
            ctrl.descend = 1'b1;
            read_addr    = sel_base + PADDR_BITS'({index, 3'b000});
         end
      end
   end

endmodule

// ----- rtl/core/ptw_rsp_reg.sv -----
// ----------------------------------------------------------------------------
// ptw_rsp_reg
// result register: holds one result until the sink takes it and lets a new
// one load in the same cycle the old one leaves
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "page_table_walker_top_macros.svh"

module ptw_rsp_reg #(
   parameter int PADDR_BITS = 52
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  logic [1:0]            result_kind,
   input  logic [PADDR_BITS-1:0] read_addr,
   input  logic [PADDR_BITS-1:0] phys_addr,
   input  logic [2:0]            fault_level,
   input  logic                  leaf_user,
   input  logic                  leaf_writable,
   input  logic                  leaf_executable,
   output logic                  can_load,
   ptw_rsp_if.source             rsp_if
);
   import ptw_pkg::*;

   logic                  valid_ff;
   logic                  valid_in;
   logic [1:0]            kind_ff;
   logic [PADDR_BITS-1:0] read_addr_ff;
   logic [PADDR_BITS-1:0] phys_addr_ff;
   logic [2:0]            fault_level_ff;
   logic [2:0]            leaf_bits_ff;

   assign can_load = !valid_ff || rsp_if.ready;
   assign valid_in = load || (valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff        <= result_kind;
         read_addr_ff   <= read_addr;
         phys_addr_ff   <= phys_addr;
         fault_level_ff <= fault_level;
         leaf_bits_ff   <= {leaf_user, leaf_writable, leaf_executable};
      end
   end

   assign rsp_if.valid           = valid_ff;
   assign rsp_if.result_kind     = kind_ff;
   assign rsp_if.read_addr       = read_addr_ff;
   assign rsp_if.phys_addr       = phys_addr_ff;
   assign rsp_if.fault_level     = fault_level_ff;
   assign rsp_if.leaf_user       = leaf_bits_ff[2];
   assign rsp_if.leaf_writable   = leaf_bits_ff[1];
   assign rsp_if.leaf_executable = leaf_bits_ff[0];

   // a load only happens into a free or draining slot
   `PTW_ASSERT_SAME(a_load_has_room, load, can_load)
   // a fault result never carries a zero level
   `PTW_ASSERT_SAME(a_fault_level_set, valid_ff && kind_ff == RSP_FAULT, fault_level_ff != 3'd0)
   // a loaded result shows up next cycle
   `PTW_ASSERT_NEXT(a_load_shows, load, valid_ff)

endmodule

// ----- rtl/core/page_table_walker_top.sv -----
// ----------------------------------------------------------------------------
// page_table_walker_top
// multi-level page table walker, one walk in flight
// ----------------------------------------------------------------------------
// Takes one transfer per cycle on req_if: a translate request (kind 0) starts
// a walk and yields an entry read address; each entry return (kind 1) yields
// the next read, a not-present fault with its level, or the translated
// address with the leaf permission bits. Every transfer is handled in the
// cycle it is taken and its result sits in one output register, so a new
// transfer is taken every cycle while rsp_if drains; requests during a walk
// and entry returns while idle are dropped without a result.
`timescale 1ns / 1ps

`include "page_table_walker_top_macros.svh"

module page_table_walker_top #(
   parameter int VADDR_BITS   = 48,
   parameter int PADDR_BITS   = 52,
   parameter int TABLE_LEVELS = 4
) (
   input  logic      clock,
   input  logic      reset,
   ptw_req_if.sink   req_if,
   ptw_rsp_if.source rsp_if
);
   import ptw_pkg::*;

   localparam int LEVEL_BITS = (TABLE_LEVELS > 2) ? $clog2(TABLE_LEVELS) : 1;
   localparam logic [LEVEL_BITS-1:0] TOP_LEVEL = LEVEL_BITS'(TABLE_LEVELS - 1);

   logic                  busy_ff;
   logic                  busy_in;
   logic [LEVEL_BITS-1:0] level_ff;
   logic [LEVEL_BITS-1:0] level_in;
   logic [VADDR_BITS-1:0] saved_vaddr_ff;
   logic [VADDR_BITS-1:0] saved_vaddr_in;

   logic                  fire;
   logic                  can_load;
   ptw_ctrl_type          ctrl;
   logic [1:0]            result_kind;
   logic [PADDR_BITS-1:0] read_addr;
   logic [PADDR_BITS-1:0] phys_addr;
   logic [2:0]            fault_level;
   logic                  leaf_user;
   logic                  leaf_writable;
   logic                  leaf_executable;

   assign req_if.ready = can_load;
   assign fire         = req_if.valid && can_load;

   ptw_step #(
      .VADDR_BITS   (VADDR_BITS),
      .PADDR_BITS   (PADDR_BITS),
      .TABLE_LEVELS (TABLE_LEVELS),
      .LEVEL_BITS   (LEVEL_BITS)
   ) u_step (
      .fire            (fire),
      .kind            (req_if.kind),
      .root_table_addr (req_if.root_table_addr),
      .virt_addr       (req_if.virt_addr),
      .entry_data      (req_if.entry_data),
      .busy            (busy_ff),
      .level           (level_ff),
      .saved_vaddr     (saved_vaddr_ff),
      .ctrl            (ctrl),
      .result_kind     (result_kind),
      .read_addr       (read_addr),
      .phys_addr       (phys_addr),
      .fault_level     (fault_level),
      .leaf_user       (leaf_user),
      .leaf_writable   (leaf_writable),
      .leaf_executable (leaf_executable)
   );

   ptw_rsp_reg #(
      .PADDR_BITS (PADDR_BITS)
   ) u_rsp_reg (
      .clock           (clock),
      .reset           (reset),
      .load            (ctrl.emit),
      .result_kind     (result_kind),
      .read_addr       (read_addr),
      .phys_addr       (phys_addr),
      .fault_level     (fault_level),
      .leaf_user       (leaf_user),
      .leaf_writable   (leaf_writable),
      .leaf_executable (leaf_executable),
      .can_load        (can_load),
      .rsp_if          (rsp_if)
   );

   // walk state
   always_comb begin
      busy_in        = busy_ff;
      level_in       = level_ff;
      saved_vaddr_in = saved_vaddr_ff;
      if (ctrl.start) begin
         busy_in        = 1'b1;
         level_in       = TOP_LEVEL;
         saved_vaddr_in = req_if.virt_addr;
      end else if (ctrl.descend) begin
         level_in = level_ff - 1'b1;
      end else if (ctrl.finish) begin
         busy_in  = 1'b0;
         level_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= 1'b0;
         level_ff       <= '0;
         saved_vaddr_ff <= '0;
      end else begin
         busy_ff        <= busy_in;
         level_ff       <= level_in;
         saved_vaddr_ff <= saved_vaddr_in;
      end
   end

   // an idle walker always rests at the lowest level
   `PTW_ASSERT_SAME(a_idle_level_zero, !busy_ff, level_ff == '0)
   // a new walk opens at the top table
   `PTW_ASSERT_NEXT(a_start_top, ctrl.start, busy_ff && level_ff == TOP_LEVEL)
   // a request during a walk gives no result
   `PTW_ASSERT_SAME(a_busy_req_dropped, fire && busy_ff && req_if.kind == REQ_TRANSLATE, !ctrl.emit)
   // a finished walk leaves the walker idle
   `PTW_ASSERT_NEXT(a_finish_idle, ctrl.finish, !busy_ff)

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the page table walker
// ----------------------------------------------------------------------------
// Drives translate requests and table entry returns into req_if and checks
// every rsp_if transfer against a cycle-free walk predictor held in a small
// scoreboard. A directed opener covers the edge cases: dropped transfers,
// faults at every level, unaligned roots and ignored upper bits. Random
// walks follow, some ending early in a fault, mixed with noise, under several idle and stall patterns.
`timescale 1ns / 1ps

module tb_top;
   import ptw_pkg::*;

   localparam int VADDR_W       = 48;
   localparam int PADDR_W       = 52;
   localparam int RANDOM_ITEMS  = 850;
   localparam int PHASE_ITEMS   = 110;
   localparam int WATCHDOG_MAX  = 10000;
   localparam int DRAIN_CYCLES  = 20;
   localparam int REPORT_MAX    = 10;

   typedef enum int {
      IDLE_NONE,
      IDLE_SEND,
      IDLE_RECV,
      IDLE_BOTH
   } idle_mode_type;

   typedef struct packed {
      req_kind_type         kind;
      logic [PADDR_W-1:0]   root;
      logic [VADDR_W-1:0]   vaddr;
      logic [63:0]          entry;
   } walk_input_type;

   typedef struct packed {
      rsp_kind_type         kind;
      logic [PADDR_W-1:0]   read_addr;
      logic [PADDR_W-1:0]   phys_addr;
      logic [FAULT_BITS-1:0] fault_level;
      logic                 user;
      logic                 writable;
      logic                 executable;
   } walk_result_type;

   class walk_scoreboard;
      logic               busy;
      logic [1:0]         level;
      logic [VADDR_W-1:0] saved_vaddr;
      walk_result_type    expected_q[$];
      int                 errors;
      int                 reported;

      function new();
         busy        = 1'b0;
         level       = 2'd0;
         saved_vaddr = '0;
         errors      = 0;
         reported    = 0;
      endfunction

      function logic [PADDR_W-1:0] slot_offset(logic [VADDR_W-1:0] va, logic [1:0] lvl);
         logic [VADDR_W-1:0]    shifted;
         logic [INDEX_BITS-1:0] idx;
         shifted = va >> (PAGE_SHIFT + LEVEL_STRIDE * lvl);
         idx     = shifted[INDEX_BITS-1:0];
         return PADDR_W'({idx, 3'b000});
      endfunction

      function void note_input(walk_input_type it);
         walk_result_type    res;
         logic [PADDR_W-1:0] frame_base;
         res        = '0;
         frame_base = {it.entry[PADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
         if (it.kind == REQ_TRANSLATE) begin
            if (busy) return;
            saved_vaddr   = it.vaddr;
            level         = 2'd3;
            busy          = 1'b1;
            res.kind      = RSP_READ;
            res.read_addr = it.root + slot_offset(it.vaddr, level);
         end else begin
            if (!busy) return;
            if (!it.entry[0]) begin
               res.kind        = RSP_FAULT;
               res.fault_level = FAULT_BITS'(level) + 1'b1;
               busy            = 1'b0;
               level           = 2'd0;
            end else if (level == 2'd0) begin
               res.kind       = RSP_DONE;
               res.phys_addr  = {it.entry[PADDR_W-1:PAGE_SHIFT],
                                 saved_vaddr[PAGE_SHIFT-1:0]};
               res.user       = it.entry[2];
               res.writable   = it.entry[1];
               res.executable = ~it.entry[63];
               busy           = 1'b0;
            end else begin
               level         = level - 1'b1;
               res.kind      = RSP_READ;
               res.read_addr = frame_base + slot_offset(saved_vaddr, level);
            end
         end
         expected_q.push_back(res);
      endfunction

      function void check_result(walk_result_type got);
         walk_result_type exp;
         logic            bad;
         if (expected_q.size() == 0) begin
            errors++;
            if (reported < REPORT_MAX) begin
               reported++;
               $display("tb_top: unexpected result kind %0d read %h phys %h fault %0d",
                        got.kind, got.read_addr, got.phys_addr, got.fault_level);
            end
            return;
         end
         exp = expected_q.pop_front();
         bad = (got.kind != exp.kind) || (got.read_addr != exp.read_addr) ||
               (got.phys_addr != exp.phys_addr) ||
               (got.fault_level != exp.fault_level) || (got.user != exp.user) ||
               (got.writable != exp.writable) || (got.executable != exp.executable);
         if (bad) begin
            errors++;
            if (reported < REPORT_MAX) begin
               reported++;
               $display("tb_top: mismatch kind %0d/%0d read %h/%h phys %h/%h",
                        exp.kind, got.kind, exp.read_addr, got.read_addr,
                        exp.phys_addr, got.phys_addr);
               $display("        fault %0d/%0d user %b/%b write %b/%b exec %b/%b",
                        exp.fault_level, got.fault_level, exp.user, got.user,
                        exp.writable, got.writable, exp.executable, got.executable);
            end
         end
      endfunction

      function void check_drained();
         if (expected_q.size() != 0) begin
            errors++;
            $display("tb_top: %0d results never arrived", expected_q.size());
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   ptw_req_if #(.VADDR_BITS(VADDR_W), .PADDR_BITS(PADDR_W)) req_if ();
   ptw_rsp_if #(.PADDR_BITS(PADDR_W)) rsp_if ();

   page_table_walker_top #(
      .VADDR_BITS(VADDR_W),
      .PADDR_BITS(PADDR_W),
      .TABLE_LEVELS(4)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_if(req_if.sink),
      .rsp_if(rsp_if.source)
   );

   walk_scoreboard sb = new();
   idle_mode_type  idle_mode = IDLE_NONE;
   int             sent_items = 0;
   int             quiet_cycles = 0;

   always #1 clock = ~clock;

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic send_item(req_kind_type kind, logic [PADDR_W-1:0] root,
                            logic [VADDR_W-1:0] va, logic [63:0] entry);
      while ((idle_mode == IDLE_SEND && $urandom_range(99) < 45) ||
             (idle_mode == IDLE_BOTH && $urandom_range(99) < 9)) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid           <= 1'b1;
      req_if.kind            <= kind;
      req_if.root_table_addr <= root;
      req_if.virt_addr       <= va;
      req_if.entry_data      <= entry;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sent_items++;
   endtask

   task automatic send_translate(logic [PADDR_W-1:0] root, logic [VADDR_W-1:0] va);
      send_item(REQ_TRANSLATE, root, va, rand64());
   endtask

   task automatic send_entry(logic [63:0] entry);
      send_item(REQ_ENTRY, PADDR_W'(rand64()), VADDR_W'(rand64()), entry);
   endtask

   task automatic random_walk();
      logic [PADDR_W-1:0] root;
      logic [63:0]        entry;
      int                 lvl;
      root = PADDR_W'(rand64());
      if ($urandom_range(99) < 80) root[PAGE_SHIFT-1:0] = '0;
      send_translate(root, VADDR_W'(rand64()));
      for (lvl = 4; lvl >= 1; lvl--) begin
         if ($urandom_range(99) < 8)
            send_translate(PADDR_W'(rand64()), VADDR_W'(rand64()));
         entry    = rand64();
         entry[0] = ($urandom_range(99) < 92);
         send_entry(entry);
         if (!entry[0]) break;
      end
   endtask

   task automatic random_noise();
      logic [63:0] entry;
      int          n;
      n = $urandom_range(4, 1);
      repeat (n) begin
         send_item(req_kind_type'($urandom_range(1)), PADDR_W'(rand64()),
                   VADDR_W'(rand64()), rand64());
      end
      // close any walk left open
      entry    = rand64();
      entry[0] = 1'b0;
      send_entry(entry);
   endtask

   always @(posedge clock) begin
      walk_result_type got;
      walk_input_type  it;
      if (reset) begin
         rsp_if.ready <= 1'b1;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got.kind        = rsp_kind_type'(rsp_if.result_kind);
            got.read_addr   = rsp_if.read_addr;
            got.phys_addr   = rsp_if.phys_addr;
            got.fault_level = rsp_if.fault_level;
            got.user        = rsp_if.leaf_user;
            got.writable    = rsp_if.leaf_writable;
            got.executable  = rsp_if.leaf_executable;
            sb.check_result(got);
         end
         if (req_if.valid && req_if.ready) begin
            it.kind  = req_kind_type'(req_if.kind);
            it.root  = req_if.root_table_addr;
            it.vaddr = req_if.virt_addr;
            it.entry = req_if.entry_data;
            sb.note_input(it);
         end
         if ((idle_mode == IDLE_RECV && $urandom_range(99) < 45) ||
             (idle_mode == IDLE_BOTH && $urandom_range(99) < 9))
            rsp_if.ready <= 1'b0;
         else
            rsp_if.ready <= 1'b1;
         if ((rsp_if.valid && rsp_if.ready) || (req_if.valid && req_if.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("tb_top: done, errors");
            $finish;
         end
      end
   end

   initial begin
      req_if.valid           = 1'b0;
      req_if.kind            = REQ_TRANSLATE;
      req_if.root_table_addr = '0;
      req_if.virt_addr       = '0;
      req_if.entry_data      = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed opener
      send_entry(64'h0000_0000_0000_0001);
      send_translate(52'h0, 48'h0);
      send_entry(64'hFFFF_FFFF_FFFF_FFFF);
      send_translate(52'hF_FFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
      send_entry(64'h0000_0000_0000_0001);
      send_entry(64'h7FF0_0000_0000_0003);
      send_entry(64'h0000_0000_0000_0007);
      send_translate(52'hF_FFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
      send_entry(64'h0);
      send_translate(52'h0_0000_0012_3000, 48'h8000_0000_0FFF);
      send_entry(64'h8000_000F_FFFF_F001);
      send_entry(64'hFFFF_FFFF_FFFF_FFFE);
      send_translate(52'h0_0000_0000_1000, 48'h7FFF_FFFF_F000);
      send_entry(64'h0000_0000_0000_1001);
      send_entry(64'h0000_0000_0000_2001);
      send_entry(64'h0);
      send_translate(52'h0_0ABC_DEF0_1000, 48'h1234_5678_9ABC);
      send_entry(64'h0000_0000_0000_5003);
      send_entry(64'h0000_0000_0000_6005);
      send_entry(64'h0000_0000_0000_7007);
      send_entry(64'h0000_0000_0000_0FFE);
      send_translate(52'hF_FFFF_FFFF_F000, 48'hFFFF_FFFF_FFFF);
      send_entry(64'hFFFF_FFFF_FFFF_FFFF);
      send_entry(64'hFFFF_FFFF_FFFF_FFFF);
      send_entry(64'hFFFF_FFFF_FFFF_FFFF);
      send_entry(64'hFFFF_FFFF_FFFF_FFF9);

      // random walks and noise, cycling through idle patterns
      begin
         int base;
         base = sent_items;
         while (sent_items - base < RANDOM_ITEMS) begin
            idle_mode = idle_mode_type'(((sent_items - base) / PHASE_ITEMS) % 4);
            if ($urandom_range(99) < 80)
               random_walk();
            else
               random_noise();
         end
      end

      req_if.valid <= 1'b0;
      idle_mode = IDLE_NONE;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      sb.check_drained();
      if (sb.errors == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule
